// File: hdl/gcsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcsa_pkg;

    // Request action codes.
    localparam logic [1:0] ACT_ALLOCATE = 2'd0;
    localparam logic [1:0] ACT_VALIDATE = 2'd1;
    localparam logic [1:0] ACT_RELEASE  = 2'd2;

    // Response status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    // Field widths fixed by the interface.
    localparam int PIN_W   = 6;
    localparam int FREQ_W  = 26;
    localparam int RES_W   = 5;
    localparam int HSLOT_W = 8;
    localparam int HTAG_W  = 16;
    localparam int OSLOT_W = 4;

    // Requested PWM setup kept in each slot.
    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic [FREQ_W-1:0] frequency;
        logic [RES_W-1:0]  resolution;
    } slot_cfg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [PIN_W-1:0]   req_pin;
        logic [FREQ_W-1:0]  req_frequency;
        logic [RES_W-1:0]   req_resolution;
        logic [HSLOT_W-1:0] handle_slot;
        logic [HTAG_W-1:0]  handle_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [OSLOT_W-1:0] slot;
        logic [HTAG_W-1:0]  tag;
        logic [PIN_W-1:0]   held_pin;
        logic [FREQ_W-1:0]  held_frequency;
        logic [RES_W-1:0]   held_resolution;
    } rsp_t;

endpackage

`default_nettype wire

// File: hdl/gcsa_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module gcsa_slot_mem
    import gcsa_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int TAG_BITS   = 16,
    parameter int SLOT_W     = 4
)
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [SLOT_W-1:0]   waddr,
    input  wire logic [TAG_BITS-1:0] wtag,
    input  wire slot_cfg_t           wcfg,
    input  wire logic                re,
    input  wire logic [SLOT_W-1:0]   raddr,
    output logic [TAG_BITS-1:0]      rtag,
    output slot_cfg_t                rcfg
);

    localparam int ENTRY_W = TAG_BITS + $bits(slot_cfg_t);

    logic [ENTRY_W-1:0] mem [SLOT_COUNT];
    logic [ENTRY_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wtag, wcfg};
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rtag = rdata_reg[ENTRY_W-1 -: TAG_BITS];
    assign rcfg = rdata_reg[$bits(slot_cfg_t)-1:0];

endmodule

`default_nettype wire

// File: hdl/gcsa_free_find.sv
`timescale 1ns / 1ps
`default_nettype none

module gcsa_free_find
#(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_W     = 4
)
(
    input  wire logic [SLOT_COUNT-1:0] taken,
    output logic                       found,
    output logic [SLOT_W-1:0]          idx
);

    // Priority encoder: the lowest free slot wins.
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!taken[i])
            begin
                found = 1'b1;
                idx   = SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/generation_checked_slot_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted request and its slot memory read are registered; the lookup state then executes it
// and registers the response once the output register is free. Requests are taken only in idle,
// not before the previous one leaves lookup, yet while its response still waits in the output register.
// Reset clears the taken flags and the tag counter; slot memory contents are read
// only for taken slots and need no clearing.

module generation_checked_slot_allocator_unit
    import gcsa_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int TAG_BITS   = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W  = (TAG_BITS > HTAG_W) ? TAG_BITS : HTAG_W;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t                  state_reg, state_next;
    req_t                    req_reg;
    rsp_t                    rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [SLOT_COUNT-1:0]   taken_reg, taken_next;
    logic [TAG_BITS-1:0]     next_tag_reg, next_tag_next;

    logic                    accept;
    logic                    out_free;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    in_range;
    logic [SLOT_W-1:0]       hidx;
    logic [SLOT_W-1:0]       acc_idx;
    logic                    tag_match;
    logic                    handle_ok;
    logic                    mem_we;
    logic [TAG_BITS-1:0]     mem_rtag;
    slot_cfg_t               mem_rcfg;
    slot_cfg_t               mem_wcfg;

    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign acc_idx = req_data.handle_slot[SLOT_W-1:0];

    gcsa_free_find #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_free_find (
        .taken (taken_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    assign mem_wcfg = '{pin:        req_reg.req_pin,
                        frequency:  req_reg.req_frequency,
                        resolution: req_reg.req_resolution};

    gcsa_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .TAG_BITS   (TAG_BITS),
        .SLOT_W     (SLOT_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (free_idx),
        .wtag  (next_tag_reg),
        .wcfg  (mem_wcfg),
        .re    (accept),
        .raddr (acc_idx),
        .rtag  (mem_rtag),
        .rcfg  (mem_rcfg)
    );

    // Handle check on the registered request and the slot read.
    assign in_range  = ({1'b0, req_reg.handle_slot} < (HSLOT_W + 1)'(SLOT_COUNT));
    assign hidx      = req_reg.handle_slot[SLOT_W-1:0];
    assign tag_match = (CMP_W'(mem_rtag) == CMP_W'(req_reg.handle_tag));
    assign handle_ok = ((req_reg.action == ACT_VALIDATE) || (req_reg.action == ACT_RELEASE))
                       && in_range && taken_reg[hidx] && tag_match;

    // Request execution in the lookup state.
    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        taken_next     = taken_reg;
        next_tag_next  = next_tag_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (req_reg.action == ACT_ALLOCATE)
                    begin
                        if (free_found)
                        begin
                            mem_we                   = 1'b1;
                            taken_next[free_idx]     = 1'b1;
                            next_tag_next            = next_tag_reg + 1'b1;
                            rsp_next.status          = STAT_OK;
                            rsp_next.slot            = OSLOT_W'(free_idx);
                            rsp_next.tag             = HTAG_W'(next_tag_reg);
                            rsp_next.held_pin        = req_reg.req_pin;
                            rsp_next.held_frequency  = req_reg.req_frequency;
                            rsp_next.held_resolution = req_reg.req_resolution;
                        end
                        else
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                    end
                    else
                    begin
                        rsp_next.slot = in_range ? OSLOT_W'(req_reg.handle_slot) : '0;
                        if (!handle_ok)
                        begin
                            rsp_next.status = STAT_INVALID;
                        end
                        else
                        begin
                            rsp_next.status = STAT_OK;
                            rsp_next.tag    = HTAG_W'(mem_rtag);
                            if (req_reg.action == ACT_VALIDATE)
                            begin
                                rsp_next.held_pin        = mem_rcfg.pin;
                                rsp_next.held_frequency  = mem_rcfg.frequency;
                                rsp_next.held_resolution = mem_rcfg.resolution;
                            end
                            else
                            begin
                                taken_next[hidx] = 1'b0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            taken_reg     <= '0;
            next_tag_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            taken_reg     <= taken_next;
            next_tag_reg  <= next_tag_next;
            if (accept)
            begin
                req_reg <= req_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/slot_allocator_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the slot allocator, keeps its own copy of the slot
// table and compares every response with the one the table predicts.
module slot_allocator_checker
    import gcsa_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  wire req_t req_data,
    input  wire logic rsp_valid,
    input  wire logic rsp_ready,
    input  wire rsp_t rsp_data,
    output int        mismatches,
    output int        pending
);

    localparam int PRINT_CAP = 40;

    // Shadow copy of the slot table.
    logic             slot_busy  [SLOT_COUNT];
    logic [HTAG_W-1:0] slot_stamp [SLOT_COUNT];
    slot_cfg_t        slot_setup [SLOT_COUNT];
    logic [HTAG_W-1:0] tag_counter;

    rsp_t expected_responses[$];
    rsp_t want;
    int   responses_seen;

    initial mismatches = 0;

    // Prints one line per mismatch, up to a cap, and always counts it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] MISMATCH response %0d: %s", $realtime, responses_seen, msg);
    endtask

    // Applies one request to the shadow table and returns the response it must cause.
    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        int   s;
        int   idx;
        logic found;
        logic in_range;
        o = '0;
        found = 1'b0;
        idx = int'(r.handle_slot);
        in_range = (idx < SLOT_COUNT);
        if (r.action == ACT_ALLOCATE) begin
            o.status = STAT_FULL;
            for (s = 0; s < SLOT_COUNT; s++) begin
                if (!found && !slot_busy[s]) begin
                    found = 1'b1;
                    slot_busy[s] = 1'b1;
                    slot_setup[s].pin = r.req_pin;
                    slot_setup[s].frequency = r.req_frequency;
                    slot_setup[s].resolution = r.req_resolution;
                    slot_stamp[s] = tag_counter;
                    tag_counter = tag_counter + 1'b1;
                    o.status = STAT_OK;
                    o.slot = s[OSLOT_W-1:0];
                    o.tag = slot_stamp[s];
                    o.held_pin = r.req_pin;
                    o.held_frequency = r.req_frequency;
                    o.held_resolution = r.req_resolution;
                end
            end
        end else begin
            o.slot = in_range ? r.handle_slot[OSLOT_W-1:0] : '0;
            o.status = STAT_INVALID;
            if ((r.action == ACT_VALIDATE || r.action == ACT_RELEASE) && in_range) begin
                if (slot_busy[idx] && slot_stamp[idx] == r.handle_tag) begin
                    o.status = STAT_OK;
                    o.tag = slot_stamp[idx];
                    if (r.action == ACT_VALIDATE) begin
                        o.held_pin = slot_setup[idx].pin;
                        o.held_frequency = slot_setup[idx].frequency;
                        o.held_resolution = slot_setup[idx].resolution;
                    end else begin
                        slot_busy[idx] = 1'b0;
                        slot_stamp[idx] = '0;
                        slot_setup[idx] = '0;
                    end
                end
            end
        end
        return o;
    endfunction

    // Field by field comparison of one response.
    task automatic compare_response(input rsp_t got, input rsp_t exp_rsp);
        if (got.status !== exp_rsp.status)
            report_mismatch($sformatf("status %0d, predicted %0d", got.status, exp_rsp.status));
        if (got.slot !== exp_rsp.slot)
            report_mismatch($sformatf("slot %0d, predicted %0d", got.slot, exp_rsp.slot));
        if (got.tag !== exp_rsp.tag)
            report_mismatch($sformatf("tag %0h, predicted %0h", got.tag, exp_rsp.tag));
        if (got.held_pin !== exp_rsp.held_pin)
            report_mismatch($sformatf("held_pin %0d, predicted %0d",
                                      got.held_pin, exp_rsp.held_pin));
        if (got.held_frequency !== exp_rsp.held_frequency)
            report_mismatch($sformatf("held_frequency %0d, predicted %0d",
                                      got.held_frequency, exp_rsp.held_frequency));
        if (got.held_resolution !== exp_rsp.held_resolution)
            report_mismatch($sformatf("held_resolution %0d, predicted %0d",
                                      got.held_resolution, exp_rsp.held_resolution));
    endtask

    // Responses are checked before the request of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_busy[s] = 1'b0;
                slot_stamp[s] = '0;
                slot_setup[s] = '0;
            end
            tag_counter = '0;
            expected_responses.delete();
            responses_seen = 0;
            pending <= 0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_responses.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = expected_responses.pop_front();
                    compare_response(rsp_data, want);
                end
                responses_seen++;
            end
            if (req_valid && req_ready)
                expected_responses.push_back(apply_request(req_data));
            pending <= expected_responses.size();
        end
    end

endmodule

// File: tb/generation_checked_slot_allocator_unit_tb.sv
`timescale 1ns / 1ps

module generation_checked_slot_allocator_unit_tb;
    import gcsa_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SLOTS         = 16;
    localparam int RANDOM_ITEMS  = 1625;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 1000;
    localparam logic [FREQ_W-1:0] FREQ_TOP = 26'd40000000;

    typedef struct packed {
        logic [OSLOT_W-1:0] slot;
        logic [HTAG_W-1:0]  tag;
    } handle_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;

    int mismatches;
    int pending;

    // Idle percentages per side, changed between phases.
    int send_idle_pct = 8;
    int recv_idle_pct = 53;
    int random_sent = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int idle_cycles = 0;

    // Live handles seen in responses, used to build well-formed requests.
    handle_t    live_handles[$];
    logic [1:0] issued_actions[$];
    logic [1:0] done_action;
    int alloc_sent = 0, validate_sent = 0, release_sent = 0, unused_sent = 0;
    int ok_seen = 0, full_seen = 0, invalid_seen = 0;

    always #1 clk = ~clk;

    generation_checked_slot_allocator_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    slot_allocator_checker #(.SLOT_COUNT(SLOTS)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .mismatches(mismatches),
        .pending   (pending)
    );

    // Response side: random stalls plus one long hold-off that backs up the block.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && random_sent >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Tracks granted handles and status counts from the response stream.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready && issued_actions.size() != 0) begin
                done_action = issued_actions.pop_front();
                if (rsp_data.status == STAT_OK)
                    ok_seen++;
                else if (rsp_data.status == STAT_FULL)
                    full_seen++;
                else
                    invalid_seen++;
                if (done_action == ACT_ALLOCATE && rsp_data.status == STAT_OK)
                    live_handles.push_back('{rsp_data.slot, rsp_data.tag});
                if (live_handles.size() > 24)
                    void'(live_handles.pop_front());
            end
            if (req_valid && req_ready)
                issued_actions.push_back(req_data.action);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
                $display("generation_checked_slot_allocator_unit_tb failed");
                $finish;
            end
        end
    end

    function automatic req_t alloc_req(input logic [PIN_W-1:0] pin,
                                       input logic [FREQ_W-1:0] freq,
                                       input logic [RES_W-1:0] res);
        req_t r;
        r.action = ACT_ALLOCATE;
        r.req_pin = pin;
        r.req_frequency = freq;
        r.req_resolution = res;
        r.handle_slot = HSLOT_W'($urandom_range(255));
        r.handle_tag = HTAG_W'($urandom_range(65535));
        return r;
    endfunction

    function automatic req_t handle_req(input logic [1:0] act,
                                        input logic [HSLOT_W-1:0] hslot,
                                        input logic [HTAG_W-1:0] htag);
        req_t r;
        r.action = act;
        r.req_pin = PIN_W'($urandom_range(63));
        r.req_frequency = FREQ_W'($urandom());
        r.req_resolution = RES_W'($urandom_range(31));
        r.handle_slot = hslot;
        r.handle_tag = htag;
        return r;
    endfunction

    // Offers one request, idling first at the current rate, and waits for acceptance.
    task automatic offer_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        case (r.action)
            ACT_ALLOCATE: alloc_sent++;
            ACT_VALIDATE: validate_sent++;
            ACT_RELEASE:  release_sent++;
            default:      unused_sent++;
        endcase
    endtask

    // Holds the request side idle until every outstanding response has arrived.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random request: mostly live handles, some corrupted or made-up ones.
    task automatic random_request(input int n, output req_t r);
        int      pick;
        int      idx;
        logic    filling;
        logic [1:0] act;
        logic [HSLOT_W-1:0] hslot;
        logic [HTAG_W-1:0]  htag;
        logic [FREQ_W-1:0]  freq;
        handle_t h;
        filling = ((n / 100) % 2) == 0;
        pick = $urandom_range(99);
        if (filling)
            act = (pick < 60) ? ACT_ALLOCATE : (pick < 78) ? ACT_VALIDATE :
                  (pick < 96) ? ACT_RELEASE : ACT_UNUSED;
        else
            act = (pick < 20) ? ACT_ALLOCATE : (pick < 45) ? ACT_VALIDATE :
                  (pick < 95) ? ACT_RELEASE : ACT_UNUSED;
        if (act == ACT_ALLOCATE) begin
            case ($urandom_range(3))
                0: freq = FREQ_W'($urandom());
                1: freq = $urandom_range(1) ? FREQ_TOP : '0;
                default: freq = FREQ_W'($urandom_range(40000000));
            endcase
            r = alloc_req(PIN_W'($urandom_range(63)), freq,
                          RES_W'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                          : $urandom_range(20)));
        end else begin
            if (live_handles.size() != 0 && $urandom_range(99) < 80) begin
                idx = $urandom_range(live_handles.size() - 1);
                h = live_handles[idx];
                hslot = HSLOT_W'(h.slot);
                htag = h.tag;
                if ($urandom_range(9) == 0)
                    htag = htag ^ (16'h1 << $urandom_range(15));
                if (act == ACT_RELEASE && $urandom_range(99) < 85)
                    live_handles.delete(idx);
            end else begin
                case ($urandom_range(3))
                    0, 1: hslot = HSLOT_W'($urandom_range(SLOTS - 1));
                    2: hslot = HSLOT_W'($urandom_range(255, SLOTS));
                    default: hslot = HSLOT_W'($urandom_range(255));
                endcase
                htag = HTAG_W'($urandom_range(1) ? $urandom_range(65535)
                                                 : $urandom_range(alloc_sent));
            end
            r = handle_req(act, hslot, htag);
        end
    endtask

    initial
    begin
        req_t r;
        int   i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extreme setups, filling the table, then every handle case.
        offer_request(alloc_req(6'd63, 26'h3FFFFFF, 5'd31));
        offer_request(alloc_req(6'd0, 26'd0, 5'd0));
        offer_request(alloc_req(6'd5, FREQ_TOP, 5'd20));
        for (i = 3; i < SLOTS; i++)
            offer_request(alloc_req(PIN_W'($urandom_range(63)),
                                    FREQ_W'($urandom_range(40000000)),
                                    RES_W'($urandom_range(20))));
        // Table is full now.
        offer_request(alloc_req(6'd1, 26'd1000, 5'd8));
        offer_request(handle_req(ACT_VALIDATE, 8'd0, 16'd0));
        offer_request(handle_req(ACT_VALIDATE, 8'd1, 16'hFFFF));
        offer_request(handle_req(ACT_VALIDATE, 8'd255, 16'd0));
        offer_request(handle_req(ACT_RELEASE, 8'd16, 16'd0));
        offer_request(handle_req(ACT_RELEASE, 8'd2, 16'd2));
        offer_request(handle_req(ACT_RELEASE, 8'd2, 16'd2));
        offer_request(handle_req(ACT_UNUSED, 8'd0, 16'd0));
        offer_request(alloc_req(6'd42, 26'd25000, 5'd12));
        offer_request(handle_req(ACT_VALIDATE, 8'd2, 16'd16));
        drain_responses();

        // Random part in three idling phases.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                drain_responses();
                send_idle_pct = 53;
                recv_idle_pct = 8;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_request(i, r);
            offer_request(r);
            random_sent = i + 1;
        end
        drain_responses();
        repeat (6) @(posedge clk);

        $display("Covered %0d requests: %0d allocate, %0d validate, %0d release, %0d unused code.",
                 alloc_sent + validate_sent + release_sent + unused_sent,
                 alloc_sent, validate_sent, release_sent, unused_sent);
        $display("Responses: %0d ok, %0d table full, %0d invalid handle; %0d mismatches.",
                 ok_seen, full_seen, invalid_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("generation_checked_slot_allocator_unit_tb passed");
        else
            $display("generation_checked_slot_allocator_unit_tb failed");
        $finish;
    end

endmodule
